### rtl/oth_pkg.sv
// Shared types and constants for the occupancy time histogram unit.
// No dependencies; used by occupancy_time_histogram_unit.
package oth_pkg;

  // Item field widths
  localparam int CMD_W     = 3;
  localparam int COUNT_W   = 5;
  localparam int QSIZE_W   = 16;
  localparam int STAMP_W   = 48;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 5;
  localparam int DUR_W     = 48;

  // Stream packing
  localparam int IN_TDATA_W  = 72;  // busy_count, queue_size, timestamp, pad
  localparam int OUT_TDATA_W = 56;  // ok, bin_index, duration, pad

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLE = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_BUSY    = 3'd1,
    CMD_QUEUE   = 3'd2,
    CMD_READOUT = 3'd3,
    CMD_STOP    = 3'd4
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 2'd0,
    KIND_BUSY   = 2'd1,
    KIND_QUEUE  = 2'd2,
    KIND_TOTAL  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STATUS,
    ST_BUSY_EMIT,
    ST_QUEUE_EMIT,
    ST_TOTAL
  } state_e;

endpackage

### rtl/occupancy_time_histogram_unit.sv
// Time-weighted occupancy histogram: busy-level and queue-size duration bins
// held in two synchronous RAMs. Depends on oth_pkg.
//
//  channel   | direction | tdata (low bit up)                  | tuser | tlast
//  ----------+-----------+-------------------------------------+-------+------
//  s_axis    | in        | busy_count, queue_size, timestamp   | cmd   | -
//  m_axis    | out       | ok, bin_index, duration             | kind  | last
//  cfg       | in        | index 0 worker_count, 1 queue enable| -     | -
//
// Items: start, update, stop are accepted in IDLE and then executed in EXEC
//   (bin read-modify-write); the status goes out once the output is free.
//   The loop through the bin RAM read latency sets this split.
// Readout: busy bins 0..worker_count, queue bins (if queue watching), total;
//   one bin per cycle from the RAM read port when the output is not stalled.
// Reset: asynchronous, clears control state and the per-entry valid bits;
//   no clearing pass, an entry that is not valid reads as zero.
// Stalls: a held result in the output register blocks the walk, the RAM read
//   is not reissued until the result is taken.
module occupancy_time_histogram_unit #(
  parameter int MAX_WORKERS = 16,
  parameter int QUEUE_BINS  = 32,
  parameter int TIME_BITS   = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [oth_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [oth_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // command items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // busy_count[4:0], queue_size[20:5], timestamp[68:21], zero pad
  input  logic [oth_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // cmd[2:0]
  input  logic [oth_pkg::CMD_W-1:0]          s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // ok[0], bin_index[5:1], duration[53:6], zero pad
  output logic [oth_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind[1:0]
  output logic [oth_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int BW = $clog2(MAX_WORKERS + 1);
  localparam int QW = $clog2(QUEUE_BINS);
  localparam int IW = (BW > QW) ? BW : QW;
  localparam int TW = TIME_BITS;
  localparam int NB = MAX_WORKERS + 1;

  localparam int CountW = oth_pkg::COUNT_W;
  localparam int QsizeW = oth_pkg::QSIZE_W;
  localparam int StampW = oth_pkg::STAMP_W;
  localparam int DurW   = oth_pkg::DUR_W;
  localparam int IndexW = oth_pkg::INDEX_W;
  localparam int CfgW   = oth_pkg::CFG_DATA_W;

  localparam int QsizeLo = CountW;
  localparam int StampLo = CountW + QsizeW;

  function automatic logic [TW-1:0] elapsed(input logic [TW-1:0] now,
                                            input logic [TW-1:0] since);
    return (now >= since) ? (now - since) : '0;
  endfunction

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // ---------------------------------------------------------------- input unpack
  logic [CountW-1:0] in_busy;
  logic [QsizeW-1:0] in_qsize;
  logic [StampW-1:0] in_stamp;
  logic [TW-1:0]     in_ts;
  logic              in_accept;

  assign in_busy   = s_axis_tdata[CountW-1:0];
  assign in_qsize  = s_axis_tdata[QsizeLo +: QsizeW];
  assign in_stamp  = s_axis_tdata[StampLo +: StampW];
  assign in_ts     = TW'(in_stamp);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- registers
  oth_pkg::state_e state_q, state_d;

  logic [CfgW-1:0]   cfg_wc_q;
  logic              cfg_qen_q;

  logic              active_q, active_d;
  logic              queue_on_q, queue_on_d;
  logic [BW-1:0]     levels_top_q, levels_top_d;
  logic [BW-1:0]     busy_level_q, busy_level_d;
  logic [QW-1:0]     queue_level_q, queue_level_d;
  logic [TW-1:0]     period_start_q, period_start_d;
  logic [TW-1:0]     busy_since_q, busy_since_d;
  logic [TW-1:0]     queue_since_q, queue_since_d;
  logic [NB-1:0]         busy_vld_q, busy_vld_d;
  logic [QUEUE_BINS-1:0] queue_vld_q, queue_vld_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              status_ok_q, status_ok_d;

  // accepted item and its elapsed times (payload, no reset)
  oth_pkg::cmd_e     cmd_q;
  logic [CountW-1:0] busy_q;
  logic [QsizeW-1:0] qsize_q;
  logic [TW-1:0]     ts_q;
  logic [TW-1:0]     el_busy_q, el_queue_q, el_total_q;

  // output register
  logic                  m_valid_q;
  logic                  m_ok_q, m_last_q;
  oth_pkg::kind_e        m_kind_q;
  logic [IndexW-1:0]     m_idx_q;
  logic [DurW-1:0]       m_dur_q;
  logic                  out_load, out_free;
  logic                  out_ok_d, out_last_d;
  oth_pkg::kind_e        out_kind_d;
  logic [IndexW-1:0]     out_idx_d;
  logic [TW-1:0]         out_dur_d;

  // ---------------------------------------------------------------- bin RAMs
  logic [TW-1:0] busy_mem [NB];
  logic [TW-1:0] queue_mem [QUEUE_BINS];
  logic [TW-1:0] busy_rdata_q, queue_rdata_q;
  logic [TW-1:0] busy_sum, queue_sum;
  logic          busy_re, busy_we, queue_re, queue_we;
  logic [BW-1:0] busy_raddr;
  logic [QW-1:0] queue_raddr;

  always_ff @(posedge clk_i) begin
    if (busy_we) begin
      busy_mem[busy_level_q] <= busy_sum;
    end
    if (busy_re) begin
      busy_rdata_q <= busy_mem[busy_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_level_q] <= queue_sum;
    end
    if (queue_re) begin
      queue_rdata_q <= queue_mem[queue_raddr];
    end
  end

  // ---------------------------------------------------------------- bin arithmetic
  // Read data belongs to the walk index during the walk, to the open level otherwise.
  logic          busy_walk, queue_walk;
  logic [BW-1:0] busy_sel;
  logic [QW-1:0] queue_sel;
  logic [TW-1:0] busy_cur, queue_cur, busy_add, queue_add;

  assign busy_walk  = (state_q == oth_pkg::ST_BUSY_EMIT);
  assign queue_walk = (state_q == oth_pkg::ST_QUEUE_EMIT);
  assign busy_sel   = busy_walk ? idx_q[BW-1:0] : busy_level_q;
  assign queue_sel  = queue_walk ? idx_q[QW-1:0] : queue_level_q;
  assign busy_cur   = busy_vld_q[busy_sel] ? busy_rdata_q : '0;
  assign queue_cur  = queue_vld_q[queue_sel] ? queue_rdata_q : '0;
  // the walk closes the open interval as it passes the current level
  assign busy_add   = (busy_sel == busy_level_q) ? el_busy_q : '0;
  assign queue_add  = (queue_sel == queue_level_q) ? el_queue_q : '0;
  assign busy_sum   = sat_add(busy_cur, busy_add);
  assign queue_sum  = sat_add(queue_cur, queue_add);

  assign out_free = !m_valid_q || m_axis_tready;

  // ---------------------------------------------------------------- control
  logic              start_bad;
  logic              busy_bad;
  logic [QsizeW-1:0] qsize_clamp;
  logic [QW-1:0]     queue_new;
  logic [IW-1:0]     idx_inc;

  assign start_bad = (cfg_wc_q == '0) || (7'(cfg_wc_q) > 7'(MAX_WORKERS))
                  || (busy_q > cfg_wc_q);
  assign busy_bad  = !active_q || (7'(busy_q) > 7'(levels_top_q));
  assign qsize_clamp = (qsize_q > QsizeW'(QUEUE_BINS - 1)) ? QsizeW'(QUEUE_BINS - 1)
                                                            : qsize_q;
  assign queue_new = QW'(qsize_clamp);
  assign idx_inc   = idx_q + 1'b1;

  always_comb begin
    state_d        = state_q;
    active_d       = active_q;
    queue_on_d     = queue_on_q;
    levels_top_d   = levels_top_q;
    busy_level_d   = busy_level_q;
    queue_level_d  = queue_level_q;
    period_start_d = period_start_q;
    busy_since_d   = busy_since_q;
    queue_since_d  = queue_since_q;
    busy_vld_d     = busy_vld_q;
    queue_vld_d    = queue_vld_q;
    idx_d          = idx_q;
    status_ok_d    = status_ok_q;
    busy_re        = 1'b0;
    busy_we        = 1'b0;
    queue_re       = 1'b0;
    queue_we       = 1'b0;
    busy_raddr     = busy_level_q;
    queue_raddr    = queue_level_q;
    out_load       = 1'b0;
    out_ok_d       = status_ok_q;
    out_kind_d     = oth_pkg::KIND_STATUS;
    out_idx_d      = '0;
    out_dur_d      = '0;
    out_last_d     = 1'b1;
    s_axis_tready  = 1'b0;

    unique case (state_q)
      oth_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        // prefetch both open bins so EXEC can update them at once
        busy_re  = 1'b1;
        queue_re = 1'b1;
        if (s_axis_tvalid) begin
          state_d = oth_pkg::ST_EXEC;
        end
      end

      oth_pkg::ST_EXEC: begin
        status_ok_d = 1'b0;
        state_d     = oth_pkg::ST_STATUS;
        unique case (cmd_q)
          oth_pkg::CMD_START: begin
            if (!start_bad) begin
              status_ok_d    = 1'b1;
              active_d       = 1'b1;
              levels_top_d   = BW'(cfg_wc_q);
              queue_on_d     = cfg_qen_q;
              period_start_d = ts_q;
              busy_since_d   = ts_q;
              queue_since_d  = ts_q;
              busy_level_d   = BW'(busy_q);
              queue_level_d  = cfg_qen_q ? queue_new : '0;
              busy_vld_d     = '0;
              queue_vld_d    = '0;
            end
          end
          oth_pkg::CMD_BUSY: begin
            if (!busy_bad) begin
              status_ok_d = 1'b1;
              if (BW'(busy_q) != busy_level_q) begin
                busy_we                  = 1'b1;
                busy_vld_d[busy_level_q] = 1'b1;
                busy_level_d             = BW'(busy_q);
                busy_since_d             = ts_q;
              end
            end
          end
          oth_pkg::CMD_QUEUE: begin
            if (active_q && queue_on_q) begin
              status_ok_d = 1'b1;
              if (queue_new != queue_level_q) begin
                queue_we                   = 1'b1;
                queue_vld_d[queue_level_q] = 1'b1;
                queue_level_d              = queue_new;
                queue_since_d              = ts_q;
              end
            end
          end
          oth_pkg::CMD_READOUT: begin
            if (active_q) begin
              idx_d      = '0;
              busy_re    = 1'b1;
              busy_raddr = '0;
              state_d    = oth_pkg::ST_BUSY_EMIT;
            end
          end
          oth_pkg::CMD_STOP: begin
            if (active_q) begin
              status_ok_d = 1'b1;
              active_d    = 1'b0;
            end
          end
          default: begin
            status_ok_d = 1'b0;
          end
        endcase
        // status straight out when the output register is free
        if (state_d == oth_pkg::ST_STATUS && out_free) begin
          out_load = 1'b1;
          out_ok_d = status_ok_d;
          state_d  = oth_pkg::ST_IDLE;
        end
      end

      oth_pkg::ST_STATUS: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = oth_pkg::ST_IDLE;
        end
      end

      oth_pkg::ST_BUSY_EMIT: begin
        if (out_free) begin
          out_load                  = 1'b1;
          out_ok_d                  = 1'b1;
          out_kind_d                = oth_pkg::KIND_BUSY;
          out_idx_d                 = IndexW'(idx_q);
          out_dur_d                 = busy_sum;
          out_last_d                = 1'b0;
          busy_vld_d[idx_q[BW-1:0]] = 1'b0;
          if (idx_q[BW-1:0] == levels_top_q) begin
            if (queue_on_q) begin
              idx_d       = '0;
              queue_re    = 1'b1;
              queue_raddr = '0;
              state_d     = oth_pkg::ST_QUEUE_EMIT;
            end else begin
              state_d = oth_pkg::ST_TOTAL;
            end
          end else begin
            idx_d      = idx_inc;
            busy_re    = 1'b1;
            busy_raddr = BW'(idx_inc);
          end
        end
      end

      oth_pkg::ST_QUEUE_EMIT: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_ok_d                   = 1'b1;
          out_kind_d                 = oth_pkg::KIND_QUEUE;
          out_idx_d                  = IndexW'(idx_q);
          out_dur_d                  = queue_sum;
          out_last_d                 = 1'b0;
          queue_vld_d[idx_q[QW-1:0]] = 1'b0;
          if (idx_q[QW-1:0] == QW'(QUEUE_BINS - 1)) begin
            state_d = oth_pkg::ST_TOTAL;
          end else begin
            idx_d       = idx_inc;
            queue_re    = 1'b1;
            queue_raddr = QW'(idx_inc);
          end
        end
      end

      oth_pkg::ST_TOTAL: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_ok_d       = 1'b1;
          out_kind_d     = oth_pkg::KIND_TOTAL;
          out_dur_d      = el_total_q;
          period_start_d = ts_q;
          busy_since_d   = ts_q;
          queue_since_d  = ts_q;
          busy_vld_d     = '0;
          queue_vld_d    = '0;
          state_d        = oth_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = oth_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= oth_pkg::ST_IDLE;
      cfg_wc_q       <= '0;
      cfg_qen_q      <= 1'b0;
      active_q       <= 1'b0;
      queue_on_q     <= 1'b0;
      levels_top_q   <= '0;
      busy_level_q   <= '0;
      queue_level_q  <= '0;
      period_start_q <= '0;
      busy_since_q   <= '0;
      queue_since_q  <= '0;
      busy_vld_q     <= '0;
      queue_vld_q    <= '0;
      idx_q          <= '0;
      status_ok_q    <= 1'b0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      active_q       <= active_d;
      queue_on_q     <= queue_on_d;
      levels_top_q   <= levels_top_d;
      busy_level_q   <= busy_level_d;
      queue_level_q  <= queue_level_d;
      period_start_q <= period_start_d;
      busy_since_q   <= busy_since_d;
      queue_since_q  <= queue_since_d;
      busy_vld_q     <= busy_vld_d;
      queue_vld_q    <= queue_vld_d;
      idx_q          <= idx_d;
      status_ok_q    <= status_ok_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          oth_pkg::CFG_WORKER_COUNT: cfg_wc_q  <= cfg_wdata_i;
          oth_pkg::CFG_QUEUE_ENABLE: cfg_qen_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  // accepted item and elapsed times, taken against the state at accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= oth_pkg::cmd_e'(s_axis_tuser);
      busy_q     <= in_busy;
      qsize_q    <= in_qsize;
      ts_q       <= in_ts;
      el_busy_q  <= elapsed(in_ts, busy_since_q);
      el_queue_q <= elapsed(in_ts, queue_since_q);
      el_total_q <= elapsed(in_ts, period_start_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_ok_q   <= out_ok_d;
      m_kind_q <= out_kind_d;
      m_idx_q  <= out_idx_d;
      m_dur_q  <= DurW'(out_dur_d);
      m_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(oth_pkg::OUT_TDATA_W - DurW - IndexW - 1)'(0),
                          m_dur_q, m_idx_q, m_ok_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

`ifndef NO_ASSERTIONS
  a_busy_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_we && busy_re))
    else $error("busy bin RAM read and write in the same cycle");

  a_queue_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(queue_we && queue_re))
    else $error("queue bin RAM read and write in the same cycle");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (busy_level_q <= levels_top_q))
    else $error("open busy level above latched worker count");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_walk |-> (active_q && idx_q[BW-1:0] <= levels_top_q))
    else $error("busy walk beyond latched worker count or while inactive");
`endif

endmodule
